// File: src/twp_pkg.sv
// Shared constants and types for the twinkle pixel step block.
// No dependencies; used by the interfaces, the top level and the testbench.
package twp_pkg;

	localparam int LEVEL_BITS_DEF = 16;
	localparam int RAND_BITS      = 31;
	localparam int FIELD_BITS     = 16;
	localparam int CFG_IDX_BITS   = 3;

	localparam logic [31:0] FIELD_MASK   = 32'h0000_FFFF;
	localparam logic [31:0] HUE_SHIFT    = 32'd128;
	localparam logic [31:0] FLARE_CHANCE = 32'd5;
	localparam logic [31:0] STOP_MARGIN  = 32'd10;

	localparam logic [31:0] START_LEVEL_RST    = 32'd40960;
	localparam logic [31:0] DIM_FLOOR_RST      = 32'd16384;
	localparam logic [31:0] FLARE_LEVEL_RST    = 32'd32768;
	localparam logic [31:0] FADE_STEP_RST      = 32'd32;
	localparam logic [31:0] STOP_FADE_STEP_RST = 32'd128;

	typedef enum logic [1:0] {
		MODE_OFF   = 2'd0,
		MODE_ON    = 2'd1,
		MODE_START = 2'd2,
		MODE_STOP  = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_START_LEVEL    = 3'd0,
		CFG_DIM_FLOOR      = 3'd1,
		CFG_FLARE_LEVEL    = 3'd2,
		CFG_FADE_STEP      = 3'd3,
		CFG_STOP_FADE_STEP = 3'd4
	} cfg_reg_t;

endpackage

// File: src/twp_if.sv
// Request channels of the twinkle pixel step block: pixel in, pixel out.
// Depends on twp_pkg.
interface twp_in_if #(
	parameter int LEVEL_BITS = twp_pkg::LEVEL_BITS_DEF
);
	logic                           valid;
	logic                           ready;
	logic [1:0]                     pixel_mode;
	logic [LEVEL_BITS-1:0]          pixel_hue;
	logic [LEVEL_BITS-1:0]          pixel_saturation;
	logic [LEVEL_BITS-1:0]          pixel_lightness;
	logic [twp_pkg::RAND_BITS-1:0]  random_word;

	modport source (output valid, pixel_mode, pixel_hue, pixel_saturation, pixel_lightness,
		random_word, input ready);
	modport sink (input valid, pixel_mode, pixel_hue, pixel_saturation, pixel_lightness,
		random_word, output ready);
endinterface

interface twp_out_if #(
	parameter int LEVEL_BITS = twp_pkg::LEVEL_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [1:0]            new_mode;
	logic [LEVEL_BITS-1:0] new_hue;
	logic [LEVEL_BITS-1:0] new_saturation;
	logic [LEVEL_BITS-1:0] new_lightness;

	modport source (output valid, new_mode, new_hue, new_saturation, new_lightness,
		input ready);
	modport sink (input valid, new_mode, new_hue, new_saturation, new_lightness,
		output ready);
endinterface

// File: src/twp_cell.sv
// One restoring-division cell: takes one dividend bit per request and hands on
// the partial remainder with the request's side data. No package dependency.
module twp_cell #(
	parameter int LEVEL_BITS = 16,
	parameter int DVD_BITS   = 31,
	parameter int SIDE_BITS  = 51
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [LEVEL_BITS-1:0] in_rem,
	input  logic [DVD_BITS-1:0]   in_dvd,
	input  logic [LEVEL_BITS-1:0] in_div,
	input  logic [SIDE_BITS-1:0]  in_side,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [LEVEL_BITS-1:0] out_rem,
	output logic [DVD_BITS-1:0]   out_dvd,
	output logic [LEVEL_BITS-1:0] out_div,
	output logic [SIDE_BITS-1:0]  out_side
);

	logic                  valid_q;
	logic [LEVEL_BITS-1:0] rem_q;
	logic [DVD_BITS-1:0]   dvd_q;
	logic [LEVEL_BITS-1:0] div_q;
	logic [SIDE_BITS-1:0]  side_q;

	logic [LEVEL_BITS:0]   trial;
	logic [LEVEL_BITS:0]   diff;
	logic [LEVEL_BITS-1:0] rem_next;

	always_comb begin
		trial    = {in_rem, in_dvd[DVD_BITS-1]};
		diff     = trial - {1'b0, in_div};
		rem_next = (trial >= {1'b0, in_div}) ? diff[LEVEL_BITS-1:0] : trial[LEVEL_BITS-1:0];
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rem_q  <= rem_next;
			dvd_q  <= {in_dvd[DVD_BITS-2:0], 1'b0};
			div_q  <= in_div;
			side_q <= in_side;
		end
	end

	assign out_valid = valid_q;
	assign out_rem   = rem_q;
	assign out_dvd   = dvd_q;
	assign out_div   = div_q;
	assign out_side  = side_q;

endmodule

// File: src/twinkle_pixel_step.sv
// Channel     | dir | payload
// pixel_in    | in  | pixel_mode, pixel_hue, pixel_saturation, pixel_lightness, random_word
// pixel_out   | out | new_mode, new_hue, new_saturation, new_lightness
// cfg_*       | in  | cfg_we, cfg_index, cfg_data (write only)
// One pixel per cycle while the output takes data; RAND_BITS (31) cells in the
// remainder chain, one cell per bit of the random word.
// Each cell stalls only when it is full and its successor cannot take data.
// Reset empties the chain and loads the register defaults.
module twinkle_pixel_step #(
	parameter int LEVEL_BITS = twp_pkg::LEVEL_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [twp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [LEVEL_BITS-1:0]             cfg_data,
	twp_in_if.sink                            pixel_in,
	twp_out_if.source                         pixel_out
);

	localparam int N_CELLS = twp_pkg::RAND_BITS;
	localparam logic [LEVEL_BITS-1:0] FMASK    = LEVEL_BITS'(twp_pkg::FIELD_MASK);
	localparam logic [LEVEL_BITS-1:0] SAT_MARK = FMASK & ~LEVEL_BITS'(1);
	localparam logic [LEVEL_BITS-1:0] HUE_SH   = LEVEL_BITS'(twp_pkg::HUE_SHIFT);

	typedef struct packed {
		logic                  use_mod;
		logic [1:0]            mode;
		logic [LEVEL_BITS-1:0] hue;
		logic [LEVEL_BITS-1:0] sat;
		logic [LEVEL_BITS-1:0] light;
	} side_t;

	localparam int SIDE_BITS = $bits(side_t);

	logic [LEVEL_BITS-1:0] start_level_q;
	logic [LEVEL_BITS-1:0] dim_floor_q;
	logic [LEVEL_BITS-1:0] flare_level_q;
	logic [LEVEL_BITS-1:0] fade_step_q;
	logic [LEVEL_BITS-1:0] stop_fade_step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_level_q    <= LEVEL_BITS'(twp_pkg::START_LEVEL_RST);
			dim_floor_q      <= LEVEL_BITS'(twp_pkg::DIM_FLOOR_RST);
			flare_level_q    <= LEVEL_BITS'(twp_pkg::FLARE_LEVEL_RST);
			fade_step_q      <= LEVEL_BITS'(twp_pkg::FADE_STEP_RST);
			stop_fade_step_q <= LEVEL_BITS'(twp_pkg::STOP_FADE_STEP_RST);
		end else if (cfg_we) begin
			unique case (twp_pkg::cfg_reg_t'(cfg_index))
				twp_pkg::CFG_START_LEVEL:    start_level_q    <= cfg_data & FMASK;
				twp_pkg::CFG_DIM_FLOOR:      dim_floor_q      <= cfg_data & FMASK;
				twp_pkg::CFG_FLARE_LEVEL:    flare_level_q    <= cfg_data & FMASK;
				twp_pkg::CFG_FADE_STEP:      fade_step_q      <= cfg_data & FMASK;
				twp_pkg::CFG_STOP_FADE_STEP: stop_fade_step_q <= cfg_data & FMASK;
				default: ;
			endcase
		end
	end

	// entry decode
	side_t                 side_in;
	logic [LEVEL_BITS-1:0] hue_in;
	logic [LEVEL_BITS-1:0] sat_in;
	logic [LEVEL_BITS-1:0] light_in;
	logic [LEVEL_BITS-1:0] span;
	logic [LEVEL_BITS:0]   stop_limit;

	always_comb begin
		hue_in     = pixel_in.pixel_hue & FMASK;
		sat_in     = pixel_in.pixel_saturation & FMASK;
		light_in   = pixel_in.pixel_lightness & FMASK;
		span       = light_in - dim_floor_q;
		stop_limit = {1'b0, stop_fade_step_q} + (LEVEL_BITS+1)'(twp_pkg::STOP_MARGIN);
		side_in.use_mod = 1'b0;
		side_in.mode    = pixel_in.pixel_mode;
		side_in.hue     = hue_in;
		side_in.sat     = sat_in;
		side_in.light   = light_in;
		unique case (twp_pkg::mode_t'(pixel_in.pixel_mode))
			twp_pkg::MODE_ON: begin
				side_in.hue = (hue_in > HUE_SH) ? hue_in - HUE_SH : hue_in;
				side_in.sat = SAT_MARK;
				if (light_in <= dim_floor_q) begin
					side_in.light = flare_level_q;
				end else begin
					side_in.use_mod = 1'b1;
					side_in.light   = light_in - fade_step_q;
				end
			end
			twp_pkg::MODE_START: begin
				side_in.mode  = twp_pkg::MODE_ON;
				side_in.sat   = SAT_MARK;
				side_in.light = start_level_q;
			end
			twp_pkg::MODE_STOP: begin
				if ({1'b0, light_in} < stop_limit) begin
					side_in.mode  = twp_pkg::MODE_OFF;
					side_in.light = '0;
				end else begin
					side_in.light = light_in - stop_fade_step_q;
				end
			end
			default: ;
		endcase
	end

	// remainder chain
	logic                       c_valid [0:N_CELLS];
	logic                       c_ready [0:N_CELLS];
	logic [LEVEL_BITS-1:0]      c_rem   [0:N_CELLS];
	logic [N_CELLS-1:0]         c_dvd   [0:N_CELLS];
	logic [LEVEL_BITS-1:0]      c_div   [0:N_CELLS];
	logic [SIDE_BITS-1:0]       c_side  [0:N_CELLS];

	assign c_valid[0]     = pixel_in.valid;
	assign pixel_in.ready = c_ready[0];
	assign c_rem[0]       = '0;
	assign c_dvd[0]       = pixel_in.random_word;
	assign c_div[0]       = span;
	assign c_side[0]      = side_in;

	for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
		twp_cell #(
			.LEVEL_BITS (LEVEL_BITS),
			.DVD_BITS   (N_CELLS),
			.SIDE_BITS  (SIDE_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (c_valid[i]),
			.in_ready  (c_ready[i]),
			.in_rem    (c_rem[i]),
			.in_dvd    (c_dvd[i]),
			.in_div    (c_div[i]),
			.in_side   (c_side[i]),
			.out_valid (c_valid[i+1]),
			.out_ready (c_ready[i+1]),
			.out_rem   (c_rem[i+1]),
			.out_dvd   (c_dvd[i+1]),
			.out_div   (c_div[i+1]),
			.out_side  (c_side[i+1])
		);
	end

	// exit: flare on a small remainder
	side_t side_out;
	logic  flare;

	always_comb begin
		side_out = side_t'(c_side[N_CELLS]);
		flare    = side_out.use_mod && (c_rem[N_CELLS] < LEVEL_BITS'(twp_pkg::FLARE_CHANCE));
	end

	assign c_ready[N_CELLS]         = pixel_out.ready;
	assign pixel_out.valid          = c_valid[N_CELLS];
	assign pixel_out.new_mode       = side_out.mode;
	assign pixel_out.new_hue        = side_out.hue;
	assign pixel_out.new_saturation = side_out.sat;
	assign pixel_out.new_lightness  = (flare ? flare_level_q : side_out.light) & FMASK;

`ifndef SYNTHESIS
	a_start_never_out: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_out.valid |-> pixel_out.new_mode != twp_pkg::MODE_START)
		else $error("start mode left the block");

	a_on_sat: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_out.valid && pixel_out.new_mode == twp_pkg::MODE_ON
		|-> pixel_out.new_saturation == SAT_MARK)
		else $error("on pixel without saturation mark");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_out.ready |-> pixel_in.ready)
		else $error("chain stalled while output drains");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!c_valid[1] |-> pixel_in.ready)
		else $error("empty first cell refuses a request");
`endif

endmodule

// File: sim/testbench.sv
// Self-checking bench for twinkle_pixel_step: a scoreboard class predicts each pixel
// update from the accepted request, and plain tasks drive pixels and register writes.
// Depends on twp_pkg, twp_in_if, twp_out_if and the twinkle_pixel_step RTL.
module testbench;
	import twp_pkg::*;

	localparam int LB         = LEVEL_BITS_DEF;
	localparam int PIPE_DEPTH = RAND_BITS;
	localparam logic [LB-1:0] SAT_MARK = ~LB'(1);

	typedef struct packed {
		mode_t                mode;
		logic [LB-1:0]        hue;
		logic [LB-1:0]        sat;
		logic [LB-1:0]        light;
		logic [RAND_BITS-1:0] rnd;
	} pixel_req_t;

	typedef struct packed {
		mode_t         mode;
		logic [LB-1:0] hue;
		logic [LB-1:0] sat;
		logic [LB-1:0] light;
	} pixel_res_t;

	class twinkle_book;
		logic [LB-1:0] start_level, dim_floor, flare_level, fade_step, stop_fade_step;
		pixel_res_t due[$];
		int faults;

		function new();
			start_level    = START_LEVEL_RST;
			dim_floor      = DIM_FLOOR_RST;
			flare_level    = FLARE_LEVEL_RST;
			fade_step      = FADE_STEP_RST;
			stop_fade_step = STOP_FADE_STEP_RST;
			faults         = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [LB-1:0] v);
			case (idx)
				CFG_START_LEVEL:    start_level    = v;
				CFG_DIM_FLOOR:      dim_floor      = v;
				CFG_FLARE_LEVEL:    flare_level    = v;
				CFG_FADE_STEP:      fade_step      = v;
				CFG_STOP_FADE_STEP: stop_fade_step = v;
				default: ;
			endcase
		endfunction

		function pixel_res_t next_pixel(pixel_req_t p);
			pixel_res_t r;
			logic [LB-1:0] span;
			logic flare;
			r.mode  = p.mode;
			r.hue   = p.hue;
			r.sat   = p.sat;
			r.light = p.light;
			case (p.mode)
				MODE_ON: begin
					if (p.hue > HUE_SHIFT)
						r.hue = p.hue - HUE_SHIFT;
					r.sat = SAT_MARK;
					if (p.light <= dim_floor)
						flare = 1'b1;
					else begin
						span  = p.light - dim_floor;
						flare = (p.rnd % span) < FLARE_CHANCE;
					end
					r.light = flare ? flare_level : p.light - fade_step;
				end
				MODE_START: begin
					r.mode  = MODE_ON;
					r.sat   = SAT_MARK;
					r.light = start_level;
				end
				MODE_STOP: begin
					// 32-bit compare, so a large stop step cannot wrap the margin
					if (p.light < stop_fade_step + STOP_MARGIN) begin
						r.mode  = MODE_OFF;
						r.light = '0;
					end else
						r.light = p.light - stop_fade_step;
				end
				default: ;
			endcase
			return r;
		endfunction

		function void take_pixel(pixel_req_t p);
			due.push_back(next_pixel(p));
		endfunction

		function void check_pixel(pixel_res_t got);
			pixel_res_t want;
			if (due.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("[%0t] result with nothing pending: mode %0d hue %h sat %h light %h",
						$realtime, got.mode, got.hue, got.sat, got.light);
				return;
			end
			want = due.pop_front();
			if (got.mode !== want.mode || got.hue !== want.hue || got.sat !== want.sat ||
					got.light !== want.light) begin
				faults++;
				if (faults <= 10)
					$display("[%0t] mismatch: want mode %0d hue %h sat %h light %h, got mode %0d hue %h sat %h light %h",
						$realtime, want.mode, want.hue, want.sat, want.light,
						got.mode, got.hue, got.sat, got.light);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [LB-1:0] cfg_data;

	twp_in_if  #(.LEVEL_BITS(LB)) in_ch ();
	twp_out_if #(.LEVEL_BITS(LB)) out_ch ();

	twinkle_pixel_step #(.LEVEL_BITS(LB)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel_in  (in_ch),
		.pixel_out (out_ch)
	);

	twinkle_book book = new();

	int send_gap_pct = 0;
	int stall_pct    = 0;
	int gap_table[4]   = '{0, 64, 0, 7};
	int stall_table[4] = '{0, 0, 64, 7};

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(negedge clk)
		out_ch.ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			book.check_pixel('{mode: mode_t'(out_ch.new_mode), hue: out_ch.new_hue,
				sat: out_ch.new_saturation, light: out_ch.new_lightness});
	end

	function automatic pixel_req_t pix(mode_t m, logic [LB-1:0] h, logic [LB-1:0] s,
			logic [LB-1:0] l, logic [RAND_BITS-1:0] r);
		return '{mode: m, hue: h, sat: s, light: l, rnd: r};
	endfunction

	task automatic send_pixel(pixel_req_t p);
		@(negedge clk);
		while ($urandom_range(99) < send_gap_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid            <= 1'b1;
		in_ch.pixel_mode       <= p.mode;
		in_ch.pixel_hue        <= p.hue;
		in_ch.pixel_saturation <= p.sat;
		in_ch.pixel_lightness  <= p.light;
		in_ch.random_word      <= p.rnd;
		do @(posedge clk); while (!in_ch.ready);
		book.take_pixel(p);
	endtask

	// hold the sender until every pending pixel is back, then let the chain empty
	task automatic settle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (book.due.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 8) @(posedge clk);
	endtask

	task automatic poke_reg(logic [CFG_IDX_BITS-1:0] idx, logic [LB-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		book.write_reg(idx, v);
	endtask

	task automatic load_regs(logic [LB-1:0] start_v, logic [LB-1:0] floor_v,
			logic [LB-1:0] flare_v, logic [LB-1:0] fade_v, logic [LB-1:0] stop_v);
		poke_reg(CFG_START_LEVEL, start_v);
		poke_reg(CFG_DIM_FLOOR, floor_v);
		poke_reg(CFG_FLARE_LEVEL, flare_v);
		poke_reg(CFG_FADE_STEP, fade_v);
		poke_reg(CFG_STOP_FADE_STEP, stop_v);
		// unmapped indexes must leave the registers alone
		for (int i = int'(CFG_STOP_FADE_STEP) + 1; i < 2 ** CFG_IDX_BITS; i++)
			poke_reg(i, $urandom);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_pixels(int count);
		pixel_req_t p;
		int unsigned sel;
		longint unsigned sp, top;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				send_gap_pct = gap_table[(i / 40) % 4];
				stall_pct    = stall_table[(i / 40) % 4];
			end
			sel = $urandom_range(99);
			if (sel < 15)
				p.mode = MODE_OFF;
			else if (sel < 60)
				p.mode = MODE_ON;
			else if (sel < 75)
				p.mode = MODE_START;
			else
				p.mode = MODE_STOP;
			p.hue = ($urandom_range(3) == 0) ? HUE_SHIFT - 2 + $urandom_range(4) : $urandom;
			p.sat = $urandom;
			p.rnd = $urandom;
			case ($urandom_range(9))
				0, 1, 2: p.light = $urandom;
				3, 4, 5: p.light = book.dim_floor + $urandom_range(1, 12);
				6:       p.light = book.dim_floor - $urandom_range(0, 3);
				7, 8:    p.light = book.stop_fade_step + STOP_MARGIN - 2 + $urandom_range(4);
				default: p.light = $urandom_range(1) ? '1 : '0;
			endcase
			// aim the random word at the flare threshold of the remainder
			if (p.light > book.dim_floor && $urandom_range(1)) begin
				sp    = p.light - book.dim_floor;
				top   = 64'h7FFF_FFF8 / sp;
				p.rnd = $urandom_range(0, top) * sp + $urandom_range(0, 7);
			end
			send_pixel(p);
		end
		send_gap_pct = 0;
		stall_pct    = 0;
	endtask

	initial begin
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_index              = CFG_START_LEVEL;
		cfg_data               = '0;
		in_ch.valid            = 1'b0;
		in_ch.pixel_mode       = MODE_OFF;
		in_ch.pixel_hue        = '0;
		in_ch.pixel_saturation = '0;
		in_ch.pixel_lightness  = '0;
		in_ch.random_word      = '0;
		out_ch.ready           = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// register defaults
		send_pixel(pix(MODE_OFF, '1, '1, '1, '1));
		send_pixel(pix(MODE_OFF, '0, '0, '0, '0));
		send_pixel(pix(MODE_ON, HUE_SHIFT + 1, '0, book.dim_floor, '0));
		send_pixel(pix(MODE_ON, HUE_SHIFT, '1, book.dim_floor - 1, '1));
		send_pixel(pix(MODE_ON, '1, 16'h1234, book.dim_floor + 1, '1));
		send_pixel(pix(MODE_ON, '0, '0, book.dim_floor + 6, FLARE_CHANCE));
		send_pixel(pix(MODE_ON, 1, '0, book.dim_floor + 6, FLARE_CHANCE - 1));
		send_pixel(pix(MODE_ON, 16'h8000, '0, '1, '0));
		send_pixel(pix(MODE_ON, 200, '0, '1, (65535 - book.dim_floor) * 3 + FLARE_CHANCE));
		send_pixel(pix(MODE_ON, HUE_SHIFT - 1, '1, '1, '1));
		send_pixel(pix(MODE_ON, 16'hAAAA, 16'h5555, '0, 31'h5555_5555));
		send_pixel(pix(MODE_START, 16'h5555, '0, '0, '0));
		send_pixel(pix(MODE_START, '1, '1, '1, '1));
		send_pixel(pix(MODE_STOP, 16'h0F0F, 16'hF0F0, book.stop_fade_step + STOP_MARGIN - 1, '0));
		send_pixel(pix(MODE_STOP, 16'hF0F0, 16'h0F0F, book.stop_fade_step + STOP_MARGIN, '1));
		send_pixel(pix(MODE_STOP, '0, '0, '0, 31'h2AAA_AAAA));
		send_pixel(pix(MODE_STOP, '1, '1, '1, '1));
		run_pixels(150);
		settle();

		load_regs('0, '0, '0, '0, '0);
		run_pixels(150);
		settle();

		load_regs('1, '1, '1, '1, '1);
		run_pixels(150);
		settle();

		// fade wraps below zero, every lit pixel is above the dim floor
		load_regs('1, '0, '0, '1, 1);
		run_pixels(150);
		settle();

		load_regs($urandom, $urandom, $urandom, $urandom_range(0, 255), $urandom_range(0, 4095));
		run_pixels(150);
		settle();

		load_regs(START_LEVEL_RST, DIM_FLOOR_RST, FLARE_LEVEL_RST, FADE_STEP_RST,
			STOP_FADE_STEP_RST);
		run_pixels(150);
		settle();

		if (book.faults == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
